// File: rtl/rv32im_execute_stage_defines.svh
// Assertion macros for the execute stage checker
`ifndef RV32IM_EXECUTE_STAGE_DEFINES_SVH
`define RV32IM_EXECUTE_STAGE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define RVX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvx check failed");
// Assert that an antecedent implies a consequent in the next cycle
`define RVX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvx check failed");
`endif

// File: rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32IM execute stage.
// ----------------------------------------------------------------------------
`default_nettype none
package rvx_pkg;
  localparam logic [6:0] OP_R      = 7'd51;
  localparam logic [6:0] OP_LOAD   = 7'd3;
  localparam logic [6:0] OP_IMM    = 7'd19;
  localparam logic [6:0] OP_JALR   = 7'd103;
  localparam logic [6:0] OP_SYS    = 7'd115;
  localparam logic [6:0] OP_STORE  = 7'd35;
  localparam logic [6:0] OP_BRANCH = 7'd99;
  localparam logic [6:0] OP_AUIPC  = 7'd23;
  localparam logic [6:0] OP_LUI    = 7'd55;
  localparam logic [6:0] OP_JAL    = 7'd111;

  localparam logic [2:0] SYS_NONE  = 3'd0;
  localparam logic [2:0] SYS_INT   = 3'd1;
  localparam logic [2:0] SYS_STR   = 3'd2;
  localparam logic [2:0] SYS_EXIT  = 3'd3;
  localparam logic [2:0] SYS_CHAR  = 3'd4;
  localparam logic [2:0] SYS_UNDEF = 3'd5;
  localparam logic [2:0] SYS_EXIT2 = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [15:0] loader_address;
    logic [7:0]  loader_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        fault;
    logic [2:0]  sys_kind;
    logic [31:0] sys_arg;
    logic        running;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_MEM, ST_WRITE, ST_OUT, ST_CLEAR
  } be_state_t;
endpackage
`default_nettype wire

// File: rtl/rvx_stream_if.sv
// ----------------------------------------------------------------------------
// rvx_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none
interface rvx_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rvx_front.sv
// ----------------------------------------------------------------------------
// rvx_front
// Accepts input words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_front (
  input  wire logic clk,
  input  wire logic rst,
  rvx_stream_if.sink   in_ch,
  rvx_stream_if.source q_ch
);
  rvx_pkg::in_word_t q [2];
  logic              wp;
  logic              rp;
  logic [1:0]        cnt;
  logic              push;
  logic              pop;

  assign in_ch.ready = (cnt != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_ch.valid && q_ch.ready;
  assign q_ch.valid  = (cnt != 2'd0);
  assign q_ch.data   = q[rp];

  // advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // store incoming word
  always_ff @(posedge clk) begin
    if (push) q[wp] <= in_ch.data;
  end
endmodule
`default_nettype wire

// File: rtl/rvx_back.sv
// ----------------------------------------------------------------------------
// rvx_back
// Executes queued words: register file, data store, multiply and divide.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_back #(
  parameter int STORE_BYTES = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  rvx_stream_if.sink   q_ch,
  rvx_stream_if.source out_ch
);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int CN = (STORE_BYTES > 32) ? STORE_BYTES : 32;
  localparam int CW = $clog2(CN);

  rvx_pkg::be_state_t state, state_next;
  rvx_pkg::in_word_t  cur;
  logic [31:0] rf [32];
  logic [7:0]  mem [STORE_BYTES];
  logic [31:0] pc;
  logic        run;
  logic [31:0] a, b, a0r, a1r;
  logic [CW-1:0] clr;
  logic [1:0]  bi;
  logic [31:0] ldv;
  logic [7:0]  rdata;
  logic [63:0] prod;
  logic [5:0]  dcnt;
  logic [31:0] dq, drem, dn, dd;
  logic        dneg_q, dneg_r;
  rvx_pkg::out_word_t res;
  logic        res_valid;

  logic [31:0] w;
  logic [6:0]  op;
  logic [4:0]  rd, rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immj, addr, tgt;
  logic [2:0]  len;
  logic        inrange;
  logic [32:0] endaddr;
  logic        mode_st;

  assign w    = cur.instruction;
  assign op   = w[6:0];
  assign rd   = w[11:7];
  assign f3   = w[14:12];
  assign rs2  = w[24:20];
  assign f7   = w[31:25];
  assign immi = {{20{w[31]}}, w[31:20]};
  assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign addr = a + ((op == rvx_pkg::OP_STORE) ? imms : immi);
  assign len  = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
  assign endaddr = {1'b0, addr} + {30'd0, len};
  assign inrange = (endaddr <= 33'(STORE_BYTES));
  assign mode_st = (op == rvx_pkg::OP_STORE);

  assign q_ch.ready   = (state == rvx_pkg::ST_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  // compute combinational result and decoded fault
  logic [31:0] val;
  logic        wr, flt, memop, take;
  logic        is_mul, is_div;
  always_comb begin
    val = 32'd0; wr = 1'b0; flt = 1'b0; memop = 1'b0; take = 1'b0;
    is_mul = 1'b0; is_div = 1'b0;
    tgt = 32'd0;
    unique case (op)
      rvx_pkg::OP_R: begin
        wr = 1'b1;
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[4:0];
            3'd2: val = {31'd0, $signed(a) < $signed(b)};
            3'd3: val = {31'd0, a < b};
            3'd4: val = a ^ b;
            3'd5: val = a >> b[4:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == 7'd32 && f3 == 3'd0) val = a - b;
        else if (f7 == 7'd32 && f3 == 3'd5) val = 32'($signed(a) >>> b[4:0]);
        else if (f7 == 7'd1 && (f3 == 3'd0 || f3 == 3'd1)) is_mul = 1'b1;
        else if (f7 == 7'd1 && (f3 == 3'd4 || f3 == 3'd6)) is_div = 1'b1;
        else flt = 1'b1;
      end
      rvx_pkg::OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = a + immi;
          3'd1: if (f7 == 7'd0) val = a << rs2; else flt = 1'b1;
          3'd2: val = {31'd0, $signed(a) < $signed(immi)};
          3'd3: val = {31'd0, a < immi};
          3'd4: val = a ^ immi;
          3'd5: begin
            if (f7 == 7'd0) val = a >> rs2;
            else if (f7 == 7'd32) val = 32'($signed(a) >>> rs2);
            else flt = 1'b1;
          end
          3'd6: val = a | immi;
          default: val = a & immi;
        endcase
      end
      rvx_pkg::OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5 || !inrange) flt = 1'b1;
        else begin wr = 1'b1; memop = 1'b1; end
      end
      rvx_pkg::OP_STORE: begin
        if (f3 > 3'd2 || !inrange) flt = 1'b1;
        else memop = 1'b1;
      end
      rvx_pkg::OP_BRANCH: begin
        tgt = pc + immb;
        if (f3 == 3'd2 || f3 == 3'd3 || tgt[1:0] != 2'd0) flt = 1'b1;
        else begin
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            default: take = a >= b;
          endcase
        end
      end
      rvx_pkg::OP_JAL: begin
        tgt = pc + immj;
        if (tgt[1:0] != 2'd0) flt = 1'b1;
        else begin wr = 1'b1; val = pc + 32'd4; take = 1'b1; end
      end
      rvx_pkg::OP_JALR: begin
        tgt = a + immi;
        if (f3 != 3'd0 || tgt[0]) flt = 1'b1;
        else begin wr = 1'b1; val = pc + 32'd4; take = 1'b1; end
      end
      rvx_pkg::OP_LUI: begin wr = 1'b1; val = {w[31:12], 12'd0}; end
      rvx_pkg::OP_AUIPC: begin wr = 1'b1; val = pc + {w[31:12], 12'd0}; end
      rvx_pkg::OP_SYS: ;
      default: flt = 1'b1;
    endcase
  end

  // divider operand magnitudes
  logic [31:0] am, bm;
  assign am = a[31] ? (32'd0 - a) : a;
  assign bm = b[31] ? (32'd0 - b) : b;
  logic [32:0] dtrial;
  assign dtrial = {drem, dn[31]} - {1'b0, dd};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rvx_pkg::ST_CLEAR: if (clr == CW'(CN - 1)) state_next = rvx_pkg::ST_IDLE;
      rvx_pkg::ST_IDLE:  if (q_ch.valid && q_ch.ready) state_next = rvx_pkg::ST_READ;
      rvx_pkg::ST_READ: begin
        if (cur.mode) state_next = rvx_pkg::ST_OUT;
        else if (is_mul) state_next = rvx_pkg::ST_MUL;
        else if (is_div && b != 32'd0 && !(a == 32'h8000_0000 && b == 32'hFFFF_FFFF))
          state_next = rvx_pkg::ST_DIV;
        else if (memop) state_next = rvx_pkg::ST_MEM;
        else state_next = rvx_pkg::ST_OUT;
      end
      rvx_pkg::ST_MUL:   state_next = rvx_pkg::ST_OUT;
      rvx_pkg::ST_DIV:   if (dcnt == 6'd31) state_next = rvx_pkg::ST_WRITE;
      rvx_pkg::ST_MEM:   if (bi == 2'(len - 3'd1)) state_next = rvx_pkg::ST_WRITE;
      rvx_pkg::ST_WRITE: state_next = rvx_pkg::ST_OUT;
      rvx_pkg::ST_OUT:   state_next = rvx_pkg::ST_IDLE;
      default:           state_next = rvx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rvx_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // data store: clear sweep, loader writes, byte-serial accesses
  logic [AW-1:0] maddr;
  assign maddr = AW'(addr + {30'd0, bi});
  always_ff @(posedge clk) begin
    if (state == rvx_pkg::ST_CLEAR && 32'(clr) < 32'(STORE_BYTES)) mem[AW'(clr)] <= 8'd0;
    else if (state == rvx_pkg::ST_READ && cur.mode &&
             {16'd0, cur.loader_address} < 32'(STORE_BYTES))
      mem[AW'(cur.loader_address)] <= cur.loader_byte;
    else if (state == rvx_pkg::ST_MEM && mode_st)
      mem[maddr] <= b[8*bi +: 8];
    rdata <= mem[maddr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 32'd0; run <= 1'b1; clr <= '0; res_valid <= 1'b0;
    end else begin
      if (state == rvx_pkg::ST_CLEAR) clr <= clr + CW'(1);
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      if (state == rvx_pkg::ST_IDLE && q_ch.valid && q_ch.ready) cur <= q_ch.data;
      if (state == rvx_pkg::ST_READ) begin
        bi <= 2'd0; dcnt <= 6'd0;
        res.next_pc <= cur.mode ? pc : (flt ? pc + 32'd4 : (take ? tgt : pc + 32'd4));
        res.fault <= cur.mode ? 1'b0 : flt;
        res.reg_written <= !cur.mode && !flt && wr && rd != 5'd0;
        res.dest_index <= (!cur.mode && !flt && wr && rd != 5'd0) ? rd : 5'd0;
        res.dest_value <= (!cur.mode && !flt && wr && rd != 5'd0) ? val : 32'd0;
        res.sys_kind <= rvx_pkg::SYS_NONE;
        res.sys_arg <= 32'd0;
        if (!cur.mode && op == rvx_pkg::OP_SYS) begin
          res.sys_arg <= a1r;
          if (a0r == 32'd1) res.sys_kind <= rvx_pkg::SYS_INT;
          else if (a0r == 32'd4) res.sys_kind <= rvx_pkg::SYS_STR;
          else if (a0r == 32'd11) res.sys_kind <= rvx_pkg::SYS_CHAR;
          else if (a0r == 32'd10) begin
            res.sys_kind <= run ? rvx_pkg::SYS_EXIT : rvx_pkg::SYS_EXIT2;
            run <= 1'b0;
          end else begin
            res.sys_kind <= rvx_pkg::SYS_UNDEF; res.sys_arg <= a0r;
          end
        end
        if (!cur.mode) pc <= (!flt && take) ? tgt : pc + 32'd4;
        if (is_div && b == 32'd0 && !flt)
          res.dest_value <= (rd == 5'd0) ? 32'd0 : (f3 == 3'd4 ? 32'hFFFF_FFFF : a);
        else if (is_div && a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
          res.dest_value <= (rd == 5'd0) ? 32'd0 : (f3 == 3'd4 ? 32'h8000_0000 : 32'd0);
        if (is_mul) prod <= 64'($signed(a) * $signed(b));
        dn <= am; dd <= bm; drem <= 32'd0; dq <= 32'd0;
        dneg_q <= a[31] ^ b[31]; dneg_r <= a[31];
        ldv <= 32'd0;
      end
      if (state == rvx_pkg::ST_MUL && rd != 5'd0)
        res.dest_value <= (f3 == 3'd0) ? prod[31:0] : prod[63:32];
      if (state == rvx_pkg::ST_DIV) begin
        dcnt <= dcnt + 6'd1;
        dn <= {dn[30:0], 1'b0};
        if (!dtrial[32]) begin drem <= dtrial[31:0]; dq <= {dq[30:0], 1'b1}; end
        else begin drem <= {drem[30:0], dn[31]}; dq <= {dq[30:0], 1'b0}; end
      end
      if (state == rvx_pkg::ST_MEM) bi <= bi + 2'd1;
      if (state == rvx_pkg::ST_MEM && bi != 2'd0) ldv[8*(bi-2'd1) +: 8] <= rdata;
      if (state == rvx_pkg::ST_WRITE && rd != 5'd0) begin
        if (is_div)
          res.dest_value <= (f3 == 3'd4) ? (dneg_q ? 32'd0 - dq : dq)
                                         : (dneg_r ? 32'd0 - drem : drem);
        else if (!mode_st) begin
          case (f3)
            3'd0: res.dest_value <= {{24{rdata[7]}}, rdata};
            3'd1: res.dest_value <= {{16{rdata[7]}}, rdata, ldv[7:0]};
            3'd4: res.dest_value <= {24'd0, rdata};
            3'd5: res.dest_value <= {16'd0, rdata, ldv[7:0]};
            default: res.dest_value <= {rdata, ldv[23:0]};
          endcase
        end
      end
      if (state == rvx_pkg::ST_OUT) begin
        res_valid <= 1'b1;
        res.running <= run;
      end
    end
  end

  // register file: read in ST_IDLE->READ transition, reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      a <= 32'd0; b <= 32'd0; a0r <= 32'd0; a1r <= 32'd0;
    end else if (state == rvx_pkg::ST_IDLE && q_ch.valid && q_ch.ready) begin
      a   <= (q_ch.data.instruction[19:15] == 5'd0) ? 32'd0 : rf[q_ch.data.instruction[19:15]];
      b   <= (q_ch.data.instruction[24:20] == 5'd0) ? 32'd0 : rf[q_ch.data.instruction[24:20]];
      a0r <= rf[10];
      a1r <= rf[11];
    end
  end

  // register file: clear during reset sweep, write back on output
  always_ff @(posedge clk) begin
    if (state == rvx_pkg::ST_CLEAR && 32'(clr) < 32'd32) rf[clr[4:0]] <= 32'd0;
    else if (state == rvx_pkg::ST_OUT && res.reg_written)
      rf[res.dest_index] <= res.dest_value;
  end
endmodule
`default_nettype wire

// File: rtl/rv32im_execute_stage.sv
// Sequencing: ALU, branch, jump and ecall words go READ then OUT; mul/mulh
// go READ, MUL, OUT; div/rem go READ, DIV, WRITE, OUT (READ then OUT for a
// zero divisor or overflow); loads and stores go READ, MEM, WRITE, OUT (one
// data byte per cycle). One word at a time; the next is accepted in the cycle
// after the result is taken. Reset: synchronous; after rst a clearing pass
// zeroes the data store and register file.
// ----------------------------------------------------------------------------
// rv32im_execute_stage
// RV32IM execute stage with a queued front end and a sequential back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32im_execute_stage #(
  parameter int STORE_BYTES = 65536
) (
  input  wire logic clk,
  input  wire logic rst,
  rvx_stream_if.sink   in_ch,
  rvx_stream_if.source out_ch
);
  rvx_stream_if #(.T(rvx_pkg::in_word_t)) q_ch ();

  rvx_front u_front (.clk(clk), .rst(rst), .in_ch(in_ch), .q_ch(q_ch));

  rvx_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk(clk), .rst(rst), .q_ch(q_ch), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// File: rtl/rvx_checker.sv
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks of the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv32im_execute_stage_defines.svh"
module rvx_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rvx_pkg::out_word_t out_data
);
  `RVX_ASSERT_IMP(a_fault_no_write, out_valid && out_data.fault, !out_data.reg_written)
  `RVX_ASSERT_IMP(a_x0_never, out_valid && out_data.reg_written, out_data.dest_index != 5'd0)
  `RVX_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `RVX_ASSERT_NEXT(a_stop_sticks, out_valid && out_ready && !out_data.running,
                   !out_valid || !out_data.running)
endmodule

bind rv32im_execute_stage rvx_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
`default_nettype wire

// File: tb/rv32im_execute_stage_test.sv
// ----------------------------------------------------------------------------
// rv32im_execute_stage_test
// Drives instruction and loader words into the execute stage under several
// idling phases and checks every result word against an in-bench ISA model.
// ----------------------------------------------------------------------------
`default_nettype none

class exec_scoreboard;
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic [7:0]  mem [int];
  logic        run;
  rvx_pkg::out_word_t pending [$];
  int errors;
  int checked;

  function new();
    for (int i = 0; i < 32; i++) regs[i] = '0;
    pc = '0;
    run = 1'b1;
    errors = 0;
    checked = 0;
  endfunction

  function logic [7:0] rd_byte(logic [31:0] a);
    if (mem.exists(int'(a[15:0]))) return mem[int'(a[15:0])];
    return 8'h00;
  endfunction

  // Execute one word on the shadow state and queue the expected result
  function void note_input(rvx_pkg::in_word_t w);
    rvx_pkg::out_word_t r;
    logic [31:0] ins, a, b, immi, val, npc, addr, tgt, offs;
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic wr, flt, take;
    logic [63:0] prod;
    int len;
    ins = w.instruction;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
    a = regs[ins[19:15]]; b = regs[ins[24:20]];
    immi = {{20{ins[31]}}, ins[31:20]};
    npc = pc + 32'd4; val = '0; wr = 0; flt = 0;
    r = '0;
    if (w.mode) begin
      mem[int'(w.loader_address)] = w.loader_byte;
      npc = pc;
    end else begin
      case (op)
        rvx_pkg::OP_R: begin
          wr = 1;
          if (f7 == 7'd0) begin
            case (f3)
              3'd0: val = a + b;
              3'd1: val = a << b[4:0];
              3'd2: val = {31'd0, $signed(a) < $signed(b)};
              3'd3: val = {31'd0, a < b};
              3'd4: val = a ^ b;
              3'd5: val = a >> b[4:0];
              3'd6: val = a | b;
              default: val = a & b;
            endcase
          end else if (f7 == 7'd32 && f3 == 3'd0) val = a - b;
          else if (f7 == 7'd32 && f3 == 3'd5) val = $signed(a) >>> b[4:0];
          else if (f7 == 7'd1 && f3 == 3'd0) val = a * b;
          else if (f7 == 7'd1 && f3 == 3'd1) begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            val = prod[63:32];
          end else if (f7 == 7'd1 && (f3 == 3'd4 || f3 == 3'd6)) begin
            if (b == 0) val = (f3 == 3'd4) ? 32'hFFFF_FFFF : a;
            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
              val = (f3 == 3'd4) ? 32'h8000_0000 : 32'd0;
            else val = (f3 == 3'd4) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
          end else flt = 1;
        end
        rvx_pkg::OP_IMM: begin
          wr = 1;
          case (f3)
            3'd0: val = a + immi;
            3'd1: if (f7 == 0) val = a << ins[24:20]; else flt = 1;
            3'd2: val = {31'd0, $signed(a) < $signed(immi)};
            3'd3: val = {31'd0, a < immi};
            3'd4: val = a ^ immi;
            3'd5: begin
              if (f7 == 0) val = a >> ins[24:20];
              else if (f7 == 7'd32) val = $signed(a) >>> ins[24:20];
              else flt = 1;
            end
            3'd6: val = a | immi;
            default: val = a & immi;
          endcase
        end
        rvx_pkg::OP_LOAD: begin
          addr = a + immi;
          len = (f3[1:0] == 0) ? 1 : (f3[1:0] == 1) ? 2 : 4;
          if (f3 == 3'd3 || f3 > 3'd5 || {32'd0, addr} + len > 64'd65536) flt = 1;
          else begin
            wr = 1;
            for (int i = 0; i < len; i++) val[8*i +: 8] = rd_byte(addr + i);
            if (f3 == 3'd0) val = {{24{val[7]}}, val[7:0]};
            else if (f3 == 3'd1) val = {{16{val[15]}}, val[15:0]};
          end
        end
        rvx_pkg::OP_STORE: begin
          addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
          len = (f3 == 0) ? 1 : (f3 == 1) ? 2 : 4;
          if (f3 > 3'd2 || {32'd0, addr} + len > 64'd65536) flt = 1;
          else for (int i = 0; i < len; i++) mem[int'(addr[15:0]) + i] = b[8*i +: 8];
        end
        rvx_pkg::OP_BRANCH: begin
          offs = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          tgt = pc + offs;
          if (f3 == 3'd2 || f3 == 3'd3 || tgt[1:0] != 0) flt = 1;
          else begin
            case (f3)
              3'd0: take = a == b;
              3'd1: take = a != b;
              3'd4: take = $signed(a) < $signed(b);
              3'd5: take = $signed(a) >= $signed(b);
              3'd6: take = a < b;
              default: take = a >= b;
            endcase
            if (take) npc = tgt;
          end
        end
        rvx_pkg::OP_JAL: begin
          offs = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          tgt = pc + offs;
          if (tgt[1:0] != 0) flt = 1;
          else begin wr = 1; val = pc + 32'd4; npc = tgt; end
        end
        rvx_pkg::OP_JALR: begin
          tgt = a + immi;
          if (f3 != 0 || tgt[0]) flt = 1;
          else begin wr = 1; val = pc + 32'd4; npc = tgt; end
        end
        rvx_pkg::OP_LUI: begin wr = 1; val = {ins[31:12], 12'd0}; end
        rvx_pkg::OP_AUIPC: begin wr = 1; val = pc + {ins[31:12], 12'd0}; end
        rvx_pkg::OP_SYS: begin
          r.sys_arg = regs[11];
          if (regs[10] == 1) r.sys_kind = rvx_pkg::SYS_INT;
          else if (regs[10] == 4) r.sys_kind = rvx_pkg::SYS_STR;
          else if (regs[10] == 11) r.sys_kind = rvx_pkg::SYS_CHAR;
          else if (regs[10] == 10) begin
            r.sys_kind = run ? rvx_pkg::SYS_EXIT : rvx_pkg::SYS_EXIT2;
            run = 1'b0;
          end else begin
            r.sys_kind = rvx_pkg::SYS_UNDEF;
            r.sys_arg = regs[10];
          end
        end
        default: flt = 1;
      endcase
    end
    if (flt) begin wr = 0; npc = pc + 32'd4; end
    if (w.mode || rd == 0) wr = 0;
    if (wr) regs[rd] = val;
    pc = npc;
    r.next_pc = npc;
    r.reg_written = wr;
    r.dest_index = wr ? rd : 5'd0;
    r.dest_value = wr ? val : 32'd0;
    r.fault = flt;
    r.running = run;
    pending.push_back(r);
  endfunction

  function void check_result(rvx_pkg::out_word_t got);
    rvx_pkg::out_word_t exp;
    checked++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.next_pc !== exp.next_pc || got.reg_written !== exp.reg_written ||
        got.dest_index !== exp.dest_index || got.dest_value !== exp.dest_value ||
        got.fault !== exp.fault || got.sys_kind !== exp.sys_kind ||
        got.sys_arg !== exp.sys_arg || got.running !== exp.running) begin
      $display("%0t: expected pc=%h wr=%b rd=%0d val=%h flt=%b sk=%0d sa=%h run=%b",
               $time, exp.next_pc, exp.reg_written, exp.dest_index, exp.dest_value,
               exp.fault, exp.sys_kind, exp.sys_arg, exp.running);
      $display("%0t: actual   pc=%h wr=%b rd=%0d val=%h flt=%b sk=%0d sa=%h run=%b",
               $time, got.next_pc, got.reg_written, got.dest_index, got.dest_value,
               got.fault, got.sys_kind, got.sys_arg, got.running);
      errors++;
    end
  endfunction
endclass

module rv32im_execute_stage_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle = 0;
  int recv_stall = 0;
  int sent = 0;
  exec_scoreboard sb;

  rvx_stream_if #(.T(rvx_pkg::in_word_t))  in_ch ();
  rvx_stream_if #(.T(rvx_pkg::out_word_t)) out_ch ();

  rv32im_execute_stage DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Check each accepted result word at the rising edge
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Idle at random, offer one word, hold until accepted, then note it
  task automatic send_word(rvx_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(w);
    sent++;
    @(negedge clk);
  endtask

  task automatic exec(logic [31:0] ins);
    rvx_pkg::in_word_t w;
    w = '0;
    w.instruction = ins;
    w.loader_address = 16'($urandom);
    w.loader_byte = 8'($urandom);
    send_word(w);
  endtask

  task automatic load_byte(logic [15:0] adr, logic [7:0] v);
    rvx_pkg::in_word_t w;
    w.mode = 1'b1;
    w.instruction = $urandom;
    w.loader_address = adr;
    w.loader_byte = v;
    send_word(w);
  endtask

  function automatic logic [31:0] i_type(logic [6:0] op, logic [2:0] f3,
      logic [4:0] rd, logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  // Mostly valid encodings with small store addresses, some raw noise
  function automatic logic [31:0] rand_word();
    logic [31:0] ins;
    int sel;
    logic [6:0] ops [10];
    ops = '{rvx_pkg::OP_R, rvx_pkg::OP_LOAD, rvx_pkg::OP_IMM, rvx_pkg::OP_JALR,
            rvx_pkg::OP_SYS, rvx_pkg::OP_STORE, rvx_pkg::OP_BRANCH,
            rvx_pkg::OP_AUIPC, rvx_pkg::OP_LUI, rvx_pkg::OP_JAL};
    ins = $urandom;
    sel = $urandom_range(99);
    if (sel < 10) return ins;
    ins[6:0] = ops[$urandom_range(9)];
    if (ins[6:0] == rvx_pkg::OP_R) begin
      case ($urandom_range(3))
        0: ins[31:25] = 7'd0;
        1: ins[31:25] = 7'd1;
        2: ins[31:25] = 7'd32;
        default: ;
      endcase
    end else if (ins[6:0] == rvx_pkg::OP_IMM && ins[13:12] == 2'b01 &&
                 $urandom_range(3) != 0)
      ins[31:25] = $urandom_range(1) ? 7'd32 : 7'd0;
    else if ((ins[6:0] == rvx_pkg::OP_LOAD || ins[6:0] == rvx_pkg::OP_STORE) &&
             $urandom_range(4) != 0) begin
      ins[19:15] = 5'd0;
      ins[31] = 1'b0;
    end else if (ins[6:0] == rvx_pkg::OP_JALR && $urandom_range(3) != 0) begin
      ins[14:12] = 3'd0;
      ins[19:15] = 5'd0;
      ins[20] = 1'b0;
    end else if (ins[6:0] == rvx_pkg::OP_BRANCH && $urandom_range(3) != 0) ins[8] = 1'b0;
    else if (ins[6:0] == rvx_pkg::OP_JAL && $urandom_range(3) != 0) ins[21] = 1'b0;
    return ins;
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: loader extremes, register seeds, each operation class
    load_byte(16'hFFFF, 8'hFF);
    load_byte(16'h0000, 8'h80);
    exec(i_type(rvx_pkg::OP_IMM, 3'd0, 5'd1, 5'd0, 12'h800));
    exec(i_type(rvx_pkg::OP_IMM, 3'd0, 5'd2, 5'd0, 12'hFFF));
    exec({20'h80000, 5'd3, rvx_pkg::OP_LUI});
    exec({7'd1, 5'd2, 5'd3, 3'd4, 5'd4, rvx_pkg::OP_R});
    exec({7'd1, 5'd2, 5'd3, 3'd6, 5'd5, rvx_pkg::OP_R});
    exec({7'd1, 5'd0, 5'd3, 3'd4, 5'd6, rvx_pkg::OP_R});
    exec({7'd1, 5'd0, 5'd3, 3'd6, 5'd6, rvx_pkg::OP_R});
    exec({7'd1, 5'd3, 5'd3, 3'd1, 5'd7, rvx_pkg::OP_R});
    exec({7'd32, 5'd1, 5'd3, 3'd5, 5'd8, rvx_pkg::OP_R});
    exec(i_type(rvx_pkg::OP_LOAD, 3'd4, 5'd9, 5'd0, 12'h7FF));
    exec(i_type(rvx_pkg::OP_LOAD, 3'd0, 5'd9, 5'd0, 12'h000));
    exec(i_type(rvx_pkg::OP_LOAD, 3'd2, 5'd9, 5'd2, 12'h000));
    exec({7'd0, 5'd2, 5'd0, 3'd3, 5'd0, rvx_pkg::OP_STORE});
    exec({7'd0, 5'd0, 5'd0, 3'd0, 5'd2, rvx_pkg::OP_BRANCH});
    exec({1'b0, 10'd1, 1'b0, 8'd0, 5'd1, rvx_pkg::OP_JAL});
    exec(i_type(rvx_pkg::OP_JALR, 3'd0, 5'd0, 5'd0, 12'd1));
    exec(32'h0000_007F);
    exec(i_type(rvx_pkg::OP_IMM, 3'd0, 5'd10, 5'd0, 12'd10));
    exec({25'd0, rvx_pkg::OP_SYS});
    exec({25'd0, rvx_pkg::OP_SYS});
    exec(i_type(rvx_pkg::OP_IMM, 3'd0, 5'd10, 5'd0, 12'd1));
    exec({25'd0, rvx_pkg::OP_SYS});
    exec({12'd0, 5'd0, 3'd0, 5'd0, rvx_pkg::OP_AUIPC});

    // Random words over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 74 : (ph == 3) ? 30 : 0;
      recv_stall = (ph == 2) ? 74 : (ph == 3) ? 30 : 0;
      for (int i = 0; i < 300; i++) begin
        if ($urandom_range(9) == 0) load_byte(16'($urandom_range(255)), 8'($urandom));
        else if ($urandom_range(29) == 0) load_byte(16'($urandom), 8'($urandom));
        else exec(rand_word());
      end
    end
    in_ch.valid <= 1'b0;
    recv_stall = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d words (ALU, M ops, memory, control, ecall, loader), %0d results checked.",
             sent, sb.checked);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
